[rtl/cfwu_pkg.sv]
// cfwu_pkg: shared types, phase codes, command codes and crc-32/mpeg-2 helpers
// for the can firmware upload core; no dependencies
package cfwu_pkg;

  // field widths
  localparam int NodeIdW   = 7;
  localparam int OffsetW   = 18;
  localparam int PageW     = 10;
  localparam int PhaseW    = 3;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 18;

  // page size in bytes, a power of two
  localparam int PageBytes = 1024;
  localparam int PageShift = $clog2(PageBytes);

  // phase codes
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhMagic = 3'd1;
  localparam logic [PhaseW-1:0] PhSize  = 3'd2;
  localparam logic [PhaseW-1:0] PhPage  = 3'd3;
  localparam logic [PhaseW-1:0] PhCheck = 3'd4;
  localparam logic [PhaseW-1:0] PhDone  = 3'd5;

  // action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActFrame = 1'b1;

  // bootloader command bytes
  localparam logic [7:0] CmdMagic = 8'h33;
  localparam logic [7:0] CmdSize  = 8'h53;  // 'S'
  localparam logic [7:0] CmdPage  = 8'h50;  // 'P'
  localparam logic [7:0] CmdCrc   = 8'h43;  // 'C'
  localparam logic [7:0] CmdErase = 8'h45;  // 'E'
  localparam logic [7:0] CmdDone  = 8'h44;  // 'D'
  localparam logic [7:0] CmdNone  = 8'h00;

  // register indexes
  localparam logic [CfgIndexW-1:0] RegNodeId    = 1'b0;
  localparam logic [CfgIndexW-1:0] RegImageSize = 1'b1;

  // frame constants
  localparam logic [10:0] LoaderId   = 11'h7dd;
  localparam logic [10:0] SdoBaseId  = 11'h600;
  localparam logic [63:0] SdoReset   = 64'h0000_0001_0250_0223;
  localparam logic [31:0] CrcPoly    = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [7:0]  FillByte   = 8'hFF;

  typedef struct packed {
    logic        action;
    logic [7:0]  cmd_byte;
    logic [31:0] magic_word;
    logic [63:0] image_data;
  } cfwu_in_t;

  typedef struct packed {
    logic               tx_valid;
    logic [10:0]        tx_id;
    logic [3:0]         tx_len;
    logic [63:0]        tx_data;
    logic [PhaseW-1:0]  phase;
    logic [PageW-1:0]   page_number;
    logic [OffsetW-1:0] next_offset;
  } cfwu_out_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [31:0]        crc;
    logic [OffsetW-1:0] offset;
    logic [PageW-1:0]   page;
  } cfwu_state_t;

  // one 32-bit word step of the msb-first crc, used only on constants
  function automatic logic [31:0] crc_shift32(input logic [31:0] x);
    logic [31:0] c;
    c = x;
    for (int i = 0; i < 32; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  // image of each single input bit under the 32-bit step
  function automatic logic [31:0][31:0] crc_cols();
    logic [31:0][31:0] cols;
    for (int i = 0; i < 32; i++) begin
      cols[i] = crc_shift32(32'h1 << i);
    end
    return cols;
  endfunction

  localparam logic [31:0][31:0] CrcCols = crc_cols();

  // linear xor network equivalent to the 32-bit step
  function automatic logic [31:0] crc_apply(input logic [31:0] x);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ CrcCols[i];
      end
    end
    return r;
  endfunction

endpackage

[rtl/cfwu_step.sv]
// cfwu_step: next-state and transmit frame logic for one received event
// depends on cfwu_pkg
module cfwu_step (
  input  cfwu_pkg::cfwu_in_t               item_i,
  input  cfwu_pkg::cfwu_state_t            state_i,
  input  logic [cfwu_pkg::NodeIdW-1:0]     node_id_i,
  input  logic [cfwu_pkg::OffsetW-1:0]     image_size_i,
  output cfwu_pkg::cfwu_state_t            state_o,
  output cfwu_pkg::cfwu_out_t              result_o
);
  import cfwu_pkg::*;

  logic [PhaseW-1:0]   phase_mid;
  logic [7:0]          cmd_mid;
  logic [31:0]         crc_mid;
  logic [OffsetW:0]    pages_sum;
  logic [OffsetW:0]    pages;
  logic [PageW+PageShift-1:0] rewind;
  logic [63:0]         bytes;
  logic [OffsetW:0]    byte_pos;
  logic [31:0]         crc_lo;
  cfwu_state_t         nxt;
  logic                tx;
  logic [10:0]         tx_id;
  logic [3:0]          tx_len;
  logic [63:0]         tx_data;

  // page count and rewind offset
  assign pages_sum = {1'b0, image_size_i} + (OffsetW+1)'(PageBytes - 1);
  assign pages     = pages_sum >> PageShift;
  assign rewind    = {state_i.page, {PageShift{1'b0}}};

  // image bytes past the end read as fill
  always_comb begin
    bytes = '0;
    byte_pos = '0;
    for (int k = 0; k < 8; k++) begin
      byte_pos = {1'b0, state_i.offset} + (OffsetW+1)'(k);
      if (byte_pos < {1'b0, image_size_i}) begin
        bytes[8*k +: 8] = item_i.image_data[8*k +: 8];
      end else begin
        bytes[8*k +: 8] = FillByte;
      end
    end
  end

  // a start action arms the exchange; otherwise a check phase pre-pass, then the per-phase handling
  always_comb begin
    nxt       = state_i;
    phase_mid = state_i.phase;
    cmd_mid   = item_i.cmd_byte;
    crc_mid   = state_i.crc;
    crc_lo    = '0;
    tx        = 1'b0;
    tx_id     = '0;
    tx_len    = '0;
    tx_data   = '0;

    if (item_i.action == ActStart) begin
      tx        = 1'b1;
      tx_id     = SdoBaseId + {4'd0, node_id_i};
      tx_len    = 4'd8;
      tx_data   = SdoReset;
      nxt.phase = PhMagic;
      nxt.page  = '0;
    end else begin
      if (state_i.phase == PhCheck) begin
        crc_mid = CrcInit;
        case (item_i.cmd_byte)
          CmdPage: begin
            phase_mid = PhPage;
            nxt.page  = state_i.page + PageW'(1);
          end
          CmdErase: begin
            phase_mid  = PhPage;
            nxt.offset = rewind[OffsetW-1:0];
            cmd_mid    = CmdNone;
          end
          CmdDone: begin
            phase_mid = PhDone;
          end
          default: begin
          end
        endcase
      end
      nxt.phase = phase_mid;
      nxt.crc   = crc_mid;

      case (phase_mid)
        PhMagic: begin
          if (cmd_mid == CmdMagic) begin
            tx        = 1'b1;
            tx_id     = LoaderId;
            tx_len    = 4'd4;
            tx_data   = {32'd0, item_i.magic_word};
            nxt.phase = PhSize;
          end
        end
        PhSize: begin
          if (cmd_mid == CmdSize) begin
            tx         = 1'b1;
            tx_id      = LoaderId;
            tx_len     = 4'd1;
            tx_data    = {56'd0, pages[7:0]};
            nxt.phase  = PhPage;
            nxt.crc    = CrcInit;
            nxt.offset = '0;
            nxt.page   = '0;
          end
        end
        PhPage: begin
          if (cmd_mid == CmdPage) begin
            crc_lo     = crc_apply(crc_mid ^ bytes[31:0]);
            nxt.crc    = crc_apply(crc_lo ^ bytes[63:32]);
            nxt.offset = state_i.offset + OffsetW'(8);
            tx         = 1'b1;
            tx_id      = LoaderId;
            tx_len     = 4'd8;
            tx_data    = bytes;
          end else if (cmd_mid == CmdCrc) begin
            tx        = 1'b1;
            tx_id     = LoaderId;
            tx_len    = 4'd4;
            tx_data   = {32'd0, crc_mid};
            nxt.phase = PhCheck;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o              = nxt;
  assign result_o.tx_valid    = tx;
  assign result_o.tx_id       = tx_id;
  assign result_o.tx_len      = tx_len;
  assign result_o.tx_data     = tx_data;
  assign result_o.phase       = nxt.phase;
  assign result_o.page_number = nxt.page;
  assign result_o.next_offset = nxt.offset;

endmodule

[rtl/can_firmware_upload_crc32_core.sv]
// can firmware upload core: uploader side of a can bootloader exchange
// an input transfer is held in the input register, then its result in the result register
// throughput: one item per cycle while out_stall_i is low; the step logic and 64-bit crc xor network sit
// between the input register and the result register
// reset: asynchronous active-low; phase idle, crc and counters zero, node 1, size 0
// depends on cfwu_pkg and cfwu_step
module can_firmware_upload_crc32_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cfwu_pkg::cfwu_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cfwu_pkg::cfwu_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [cfwu_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [cfwu_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import cfwu_pkg::*;

  logic                 in_valid_q;
  cfwu_in_t             in_q;
  logic                 out_valid_q;
  cfwu_out_t            out_q;
  cfwu_state_t          state_q;
  cfwu_state_t          state_d;
  cfwu_out_t            result_d;
  logic [NodeIdW-1:0]   node_id_q;
  logic [OffsetW-1:0]   image_size_q;
  logic                 advance;
  logic                 in_take;

  // handshake: an item moves to the result register when it is free or leaving
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= NodeIdW'(1);
      image_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNodeId:    node_id_q    <= cfg_wdata_i[NodeIdW-1:0];
        RegImageSize: image_size_q <= cfg_wdata_i[OffsetW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // step logic
  cfwu_step u_step (
    .item_i       (in_q),
    .state_i      (state_q),
    .node_id_i    (node_id_q),
    .image_size_i (image_size_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // uploader state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhIdle, crc: '0, offset: '0, page: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held item never overwrites a result that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("pending item not held while result stalled");

  // a result without transmission carries an empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.tx_valid |->
      out_q.tx_id == '0 && out_q.tx_len == '0 && out_q.tx_data == '0)
    else $error("frame fields set without transmission");

  // once started, the exchange never returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != PhIdle |=> state_q.phase != PhIdle)
    else $error("phase fell back to idle");

  // a start transfer always lands in the magic phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.action == ActStart |=> state_q.phase == PhMagic)
    else $error("start did not arm the exchange");

endmodule
